// File: rtl/pmfb_pkg.sv
package pmfb_pkg;

  localparam int DEF_WIDTH  = 128;
  localparam int DEF_HEIGHT = 64;
  localparam int COORD_W    = 9;

  localparam logic [2:0] ACT_SET_PIXEL   = 3'd0;
  localparam logic [2:0] ACT_READ_PIXEL  = 3'd1;
  localparam logic [2:0] ACT_CLEAR_ALL   = 3'd2;
  localparam logic [2:0] ACT_INVERT_ALL  = 3'd3;
  localparam logic [2:0] ACT_CLEAR_RECT  = 3'd4;
  localparam logic [2:0] ACT_INVERT_RECT = 3'd5;
  localparam logic [2:0] ACT_IMAGE_START = 3'd6;
  localparam logic [2:0] ACT_IMAGE_BYTE  = 3'd7;

  localparam logic [1:0] REG_CLIP_X      = 2'd0;
  localparam logic [1:0] REG_CLIP_Y      = 2'd1;
  localparam logic [1:0] REG_CLIP_WIDTH  = 2'd2;
  localparam logic [1:0] REG_CLIP_HEIGHT = 2'd3;

  typedef struct packed {
    logic               empty;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
  } win_t;

  function automatic logic signed [17:0] ext16(input logic signed [15:0] v);
    return $signed({{2{v[15]}}, v});
  endfunction

  function automatic logic signed [17:0] smax(input logic signed [17:0] a,
                                              input logic signed [17:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [17:0] smin(input logic signed [17:0] a,
                                              input logic signed [17:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// File: rtl/pmfb_store.sv
module pmfb_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/pmfb_clip.sv
module pmfb_clip import pmfb_pkg::*; #(
  parameter int DISPLAY_WIDTH  = DEF_WIDTH,
  parameter int DISPLAY_HEIGHT = DEF_HEIGHT
) (
  input  logic               image_mode,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] w,
  input  logic signed [15:0] h,
  input  logic signed [15:0] clip_x,
  input  logic signed [15:0] clip_y,
  input  logic signed [15:0] clip_width,
  input  logic signed [15:0] clip_height,
  output win_t               win
);

  localparam logic signed [17:0] XMAX = 18'(DISPLAY_WIDTH - 1);
  localparam logic signed [17:0] YMAX = 18'(DISPLAY_HEIGHT - 1);
  localparam logic signed [17:0] ONE  = 18'sd1;
  localparam logic signed [17:0] ZERO = 18'sd0;

  logic signed [17:0] cxl, cxh, cyl, cyh, xl, xh, yl, yh;
  logic bad_size;

  assign cxl = image_mode ? ext16(clip_x) : ZERO;
  assign cyl = image_mode ? ext16(clip_y) : ZERO;
  assign cxh = image_mode ? ext16(clip_x) + ext16(clip_width) - ONE : XMAX;
  assign cyh = image_mode ? ext16(clip_y) + ext16(clip_height) - ONE : YMAX;

  assign xl = smax(smax(ext16(x), cxl), ZERO);
  assign yl = smax(smax(ext16(y), cyl), ZERO);
  assign xh = smin(smin(ext16(x) + ext16(w) - ONE, cxh), XMAX);
  assign yh = smin(smin(ext16(y) + ext16(h) - ONE, cyh), YMAX);

  assign bad_size = (w <= 16'sd0) || (h <= 16'sd0) ||
                    (image_mode && ((clip_width <= 16'sd0) || (clip_height <= 16'sd0)));

  always_comb begin
    win.empty = bad_size || (xl > xh) || (yl > yh);
    win.x0    = xl[COORD_W-1:0];
    win.x1    = xh[COORD_W-1:0];
    win.y0    = yl[COORD_W-1:0];
    win.y1    = yh[COORD_W-1:0];
  end

endmodule

// File: rtl/paged_monochrome_framebuffer_engine_core.sv
// Paged monochrome frame buffer engine.
// Commands arrive on the s_axis channel, one per transfer; the command code
// travels in s_axis_tuser and its operands in s_axis_tdata. Only a read pixel
// command gives a result, a single transfer on m_axis carrying the pixel.
// A command's store update is a read-modify-write through the registered
// read port and the write port of the store: each byte is read in ST_RD and
// written back in ST_WR. Set pixel leaves the store alone when off the screen,
// read pixel only reads and gives the result from ST_RESULT, and an image byte
// hits no, one or two store pages. Rectangle, whole-screen and image start
// commands walk the covered bytes, page by page and column by column.
// s_axis_tready is high only while the sequencer is idle.
// The clip registers are written through cfg_we, cfg_index and cfg_data and
// take effect at the next image start.
// After reset the store is cleared one byte a cycle, all
// DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT / 8) bytes, with s_axis_tready low.
// A result waits in the output register while m_axis_tready is low; other
// commands are still taken, and a further read waits until it has gone.
module paged_monochrome_framebuffer_engine_core import pmfb_pkg::*; #(
  parameter int DISPLAY_WIDTH  = DEF_WIDTH,
  parameter int DISPLAY_HEIGHT = DEF_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x[15:0], y[31:16], width[47:32], height[63:48], image_byte[71:64]
  input  logic [71:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel[0]
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PAGES = (DISPLAY_HEIGHT + 7) / 8;
  localparam int DEPTH = PAGES * DISPLAY_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PGW   = $clog2(PAGES) + 1;
  localparam logic signed [17:0] XLIM = 18'(DISPLAY_WIDTH);
  localparam logic signed [17:0] YLIM = 18'(DISPLAY_HEIGHT);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_RD, ST_WR, ST_RESULT} state_t;
  typedef enum logic [2:0] {JOB_WALK, JOB_PIXEL, JOB_READ, JOB_BLIT0, JOB_BLIT1} job_t;
  typedef enum logic [1:0] {OP_CLR, OP_INV, OP_OR} op_t;

  state_t state;
  job_t   job;
  op_t    op;

  logic [AW-1:0]      clr_cnt;
  logic [PGW-1:0]     cur_page, wp1;
  logic [COORD_W-1:0] cur_col, wx0, wx1, wy0, wy1;
  logic [7:0]         mask, hi_mask;

  logic signed [15:0] clip_x, clip_y, clip_width, clip_height;
  logic               blit_active;
  logic signed [15:0] ox, oy, cols, rows;
  logic [15:0]        bcol;
  logic [12:0]        bpage;
  logic [COORD_W-1:0] bl, br, bt, bb;

  logic signed [15:0] in_x, in_y, in_w, in_h;
  logic [7:0]         in_byte;
  logic [2:0]         act;
  logic               accept;
  win_t               win;

  logic [AW-1:0] addr, wr_addr;
  logic [7:0]    rd_data, wr_data, walk_mask, eff_mask;
  logic          wr_en;

  assign in_x    = $signed(s_axis_tdata[15:0]);
  assign in_y    = $signed(s_axis_tdata[31:16]);
  assign in_w    = $signed(s_axis_tdata[47:32]);
  assign in_h    = $signed(s_axis_tdata[63:48]);
  assign in_byte = s_axis_tdata[71:64];
  assign act     = s_axis_tuser;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  pmfb_clip #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
  ) u_clip (
    .image_mode (act == ACT_IMAGE_START),
    .x          (in_x),
    .y          (in_y),
    .w          (in_w),
    .h          (in_h),
    .clip_x     (clip_x),
    .clip_y     (clip_y),
    .clip_width (clip_width),
    .clip_height(clip_height),
    .win        (win)
  );

  assign addr = AW'(32'(cur_page) * DISPLAY_WIDTH + 32'(cur_col));

  always_comb begin
    logic [COORD_W:0] row;
    for (int i = 0; i < 8; i++) begin
      row = (COORD_W + 1)'({cur_page, 3'b000}) + (COORD_W + 1)'(i);
      walk_mask[i] = (row >= {1'b0, wy0}) && (row <= {1'b0, wy1});
    end
  end

  assign eff_mask = (job == JOB_WALK) ? walk_mask : mask;

  always_comb begin
    case (op)
      OP_CLR:  wr_data = rd_data & ~eff_mask;
      OP_INV:  wr_data = rd_data ^ eff_mask;
      OP_OR:   wr_data = rd_data | eff_mask;
      default: wr_data = rd_data;
    endcase
    if (state == ST_CLEAR) begin
      wr_data = 8'h00;
    end
  end

  assign wr_en   = (state == ST_CLEAR) || (state == ST_WR);
  assign wr_addr = (state == ST_CLEAR) ? clr_cnt : addr;

  pmfb_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .rd_addr(addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Single pixel decode.
  logic on_screen;
  assign on_screen = (ext16(in_x) >= 18'sd0) && (ext16(in_x) < XLIM) &&
                     (ext16(in_y) >= 18'sd0) && (ext16(in_y) < YLIM);

  // Image byte placement.
  logic signed [17:0] cx, base, p0;
  logic               col_in;
  logic [7:0]         row_ok, lo_part, hi_part;
  logic [15:0]        shifted;
  logic [16:0]        bcol_inc;
  logic signed [15:0] rows_m1;

  assign cx     = ext16(ox) + $signed({2'b00, bcol});
  assign base   = ext16(oy) + $signed({2'b00, bpage, 3'b000});
  assign col_in = (cx >= $signed({9'b0, bl})) && (cx <= $signed({9'b0, br}));

  always_comb begin
    logic signed [17:0] cy;
    for (int i = 0; i < 8; i++) begin
      cy = base + 18'(i);
      row_ok[i] = (cy >= $signed({9'b0, bt})) && (cy <= $signed({9'b0, bb}));
    end
  end

  assign shifted  = {8'h00, in_byte & row_ok} << base[2:0];
  assign lo_part  = col_in ? shifted[7:0] : 8'h00;
  assign hi_part  = col_in ? shifted[15:8] : 8'h00;
  assign p0       = base >>> 3;
  assign bcol_inc = {1'b0, bcol} + 17'd1;
  assign rows_m1  = rows - 16'sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      job           <= JOB_WALK;
      op            <= OP_CLR;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
      clip_x        <= 16'sd0;
      clip_y        <= 16'sd0;
      clip_width    <= 16'sd128;
      clip_height   <= 16'sd64;
      blit_active   <= 1'b0;
      bcol          <= '0;
      bpage         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLIP_X:      clip_x      <= $signed(cfg_data);
          REG_CLIP_Y:      clip_y      <= $signed(cfg_data);
          REG_CLIP_WIDTH:  clip_width  <= $signed(cfg_data);
          REG_CLIP_HEIGHT: clip_height <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && (state != ST_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            case (act)
              ACT_SET_PIXEL, ACT_READ_PIXEL: begin
                op <= OP_OR;
                if (act == ACT_READ_PIXEL) begin
                  job      <= JOB_READ;
                  mask     <= on_screen ? (8'h01 << in_y[2:0]) : 8'h00;
                  cur_page <= on_screen ? PGW'(in_y[COORD_W-1:3]) : '0;
                  cur_col  <= on_screen ? in_x[COORD_W-1:0] : '0;
                  state    <= ST_RD;
                end else begin
                  job      <= JOB_PIXEL;
                  mask     <= 8'h01 << in_y[2:0];
                  cur_page <= PGW'(in_y[COORD_W-1:3]);
                  cur_col  <= in_x[COORD_W-1:0];
                  state    <= on_screen ? ST_RD : ST_IDLE;
                end
              end
              ACT_CLEAR_ALL, ACT_INVERT_ALL: begin
                job      <= JOB_WALK;
                op       <= (act == ACT_CLEAR_ALL) ? OP_CLR : OP_INV;
                wx0      <= '0;
                wx1      <= COORD_W'(DISPLAY_WIDTH - 1);
                wy0      <= '0;
                wy1      <= COORD_W'(DISPLAY_HEIGHT - 1);
                cur_col  <= '0;
                cur_page <= '0;
                wp1      <= PGW'(PAGES - 1);
                state    <= ST_RD;
              end
              ACT_CLEAR_RECT, ACT_INVERT_RECT, ACT_IMAGE_START: begin
                job      <= JOB_WALK;
                op       <= (act == ACT_INVERT_RECT) ? OP_INV : OP_CLR;
                wx0      <= win.x0;
                wx1      <= win.x1;
                wy0      <= win.y0;
                wy1      <= win.y1;
                cur_col  <= win.x0;
                cur_page <= PGW'(win.y0 >> 3);
                wp1      <= PGW'(win.y1 >> 3);
                state    <= win.empty ? ST_IDLE : ST_RD;
                if (act == ACT_IMAGE_START) begin
                  blit_active <= !win.empty;
                  ox          <= in_x;
                  oy          <= in_y;
                  cols        <= in_w;
                  rows        <= in_h;
                  bcol        <= '0;
                  bpage       <= '0;
                  bl          <= win.x0;
                  br          <= win.x1;
                  bt          <= win.y0;
                  bb          <= win.y1;
                end
              end
              default: begin
                if (blit_active) begin
                  if (bcol_inc >= 17'(cols)) begin
                    bcol  <= '0;
                    bpage <= bpage + 13'd1;
                    if ((14'(bpage) + 14'd1) > 14'(rows_m1[15:3])) begin
                      blit_active <= 1'b0;
                    end
                  end else begin
                    bcol <= bcol_inc[15:0];
                  end
                  op      <= OP_OR;
                  cur_col <= cx[COORD_W-1:0];
                  hi_mask <= hi_part;
                  if (lo_part != 8'h00) begin
                    cur_page <= PGW'(p0);
                    mask     <= lo_part;
                    job      <= (hi_part != 8'h00) ? JOB_BLIT0 : JOB_BLIT1;
                    state    <= ST_RD;
                  end else if (hi_part != 8'h00) begin
                    cur_page <= PGW'(p0 + 18'sd1);
                    mask     <= hi_part;
                    job      <= JOB_BLIT1;
                    state    <= ST_RD;
                  end
                end
              end
            endcase
          end
        end

        ST_RD: begin
          state <= (job == JOB_READ) ? ST_RESULT : ST_WR;
        end

        ST_WR: begin
          case (job)
            JOB_WALK: begin
              if (cur_col == wx1) begin
                if (cur_page == wp1) begin
                  state <= ST_IDLE;
                end else begin
                  cur_page <= cur_page + PGW'(1);
                  cur_col  <= wx0;
                  state    <= ST_RD;
                end
              end else begin
                cur_col <= cur_col + COORD_W'(1);
                state   <= ST_RD;
              end
            end
            JOB_BLIT0: begin
              cur_page <= cur_page + PGW'(1);
              mask     <= hi_mask;
              job      <= JOB_BLIT1;
              state    <= ST_RD;
            end
            default: state <= ST_IDLE;
          endcase
        end

        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'b0, |(rd_data & mask)};
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/pmfb_checker.sv
module pmfb_checker import pmfb_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // The store is being cleared straight after reset, so no command is taken.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("command taken during the clearing pass");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("result padding not zero");

  // Only a read pixel command may produce a result transfer.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_READ_PIXEL) && !m_axis_tvalid)
    |=> !m_axis_tvalid)
    else $error("result without a read command");

endmodule

bind paged_monochrome_framebuffer_engine_core pmfb_checker u_pmfb_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
